FILE: rtl/core/agr_pkg.sv
// Shared constants, types and helpers for the ARMA/GARCH return step block.
package agr_pkg;

  localparam int AR_ORDER_DEF = 2;
  localparam int MA_ORDER_DEF = 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_RETURN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AR_LAG1       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AR_LAG2       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MA_LAG1       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA         = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOCK_WEIGHT  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST       = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DOWNSIDE      = 8'd7;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [39:0] SIGMA_FLOOR_V = 40'd110;
  localparam logic [52:0] VAR_LO        = 53'd10995;
  localparam logic [52:0] VAR_HI        = 53'd10995116278;

  localparam int ACC_W = 36;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SQRT  = 16'h0002,
    S_SHOCK = 16'h0004,
    S_AR1   = 16'h0008,
    S_AR2   = 16'h0010,
    S_MA1   = 16'h0020,
    S_SQ    = 16'h0040,
    S_GLO   = 16'h0080,
    S_GHI   = 16'h0100,
    S_SADD  = 16'h0200,
    S_ALO   = 16'h0400,
    S_AHI   = 16'h0800,
    S_BLO   = 16'h1000,
    S_BHI   = 16'h2000,
    S_FIN   = 16'h4000,
    S_PUT   = 16'h8000
  } state_t;

  // arithmetic shift right, rounding half away from zero
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v, input int sh);
    logic [65:0] mag;
    logic [65:0] half;
    begin
      half = 66'd1 << (sh - 1);
      mag  = v[65] ? 66'(-v) : 66'(v);
      mag  = (mag + half) >> sh;
      rnd_shr = v[65] ? -$signed(mag) : $signed(mag);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    begin
      if (v > ACC_W'(64'sd2147483647))
        sat32 = 32'sh7fffffff;
      else if (v < -ACC_W'(64'sd2147483648))
        sat32 = 32'sh80000000;
      else
        sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: rtl/core/agr_if.sv
// Valid/ready channel interfaces for step requests and results.
interface agr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] innovation;
  logic [39:0] start_variance;

  modport source (output valid, op, innovation, start_variance, input ready);
  modport sink (input valid, op, innovation, start_variance, output ready);
endinterface

interface agr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] step_return;
  logic [31:0] step_shock;
  logic [39:0] next_variance;

  modport source (output valid, step_return, step_shock, next_variance, input ready);
  modport sink (input valid, step_return, step_shock, next_variance, output ready);
endinterface

FILE: rtl/core/arma_garch_return_step.sv
// ARMA(2,1) return generator with GARCH(1,1) leverage variance, one shared multiplier.
//
// Channels: steps (sink) carries op, innovation and start_variance; results
// (source) carries step_return, step_shock and next_variance, one word per
// accepted word. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); indexes above 7 are ignored. Write only while idle.
// A step word runs a restoring square root for sigma in S_SQRT, then the
// multiply/accumulate states S_SHOCK to S_FIN on one shared 33x33 signed
// multiplier, and offers its result from S_PUT; steps.ready stays low until
// that result has moved to the output register, so a new word is not taken
// before the last one is through. A start word clears history, loads the
// variance and offers its result from S_PUT.
// The result sits in an output register; steps.ready is high while the
// sequencer is idle, even with a result waiting. A finished word waits in
// S_PUT while an earlier result is still held and results.ready stays low.
// Reset (rst, synchronous) clears configuration, history and variance.
module arma_garch_return_step #(
  parameter int AR_ORDER = agr_pkg::AR_ORDER_DEF,
  parameter int MA_ORDER = agr_pkg::MA_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [agr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [agr_pkg::CFG_DATA_W-1:0] cfg_data,
  agr_in_if.sink                        steps,
  agr_out_if.source                     results
);

  localparam int AW = agr_pkg::ACC_W;

  logic signed [31:0] mu, a1, a2, m1;
  logic [39:0] omega;
  logic [31:0] alpha, beta, gamma_w;

  logic signed [31:0] r0, r1, sh0;
  logic [39:0] cvar;

  agr_pkg::state_t state;

  logic        is_start;
  logic signed [31:0] z;
  logic [55:0] xs;
  logic [30:0] rem;
  logic [27:0] root;
  logic [4:0]  cnt;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  logic signed [31:0] e;
  logic signed [AW-1:0] acc;
  logic [62:0] e2;
  logic [63:0] s;
  logic [96:0] wacc;
  logic [52:0] vacc;

  logic signed [31:0] pend_ret, pend_shock;
  logic [39:0] pend_var;

  logic signed [31:0] out_ret, out_shock;
  logic [39:0] out_var;
  logic out_valid;

  logic [96:0] full;
  logic [30:0] rs;
  logic [30:0] trial;
  logic [39:0] vsel;
  logic signed [65:0] rterm;
  logic [66:0] gsum;
  logic [63:0] s_next;
  logic [52:0] vn;
  logic put_ok;

  assign steps.ready           = (state == agr_pkg::S_IDLE);
  assign results.valid         = out_valid;
  assign results.step_return   = out_ret;
  assign results.step_shock    = out_shock;
  assign results.next_variance = out_var;

  assign full  = wacc + {1'b0, prod[63:0], 32'b0};
  assign rs    = {rem[28:0], xs[55:54]};
  assign trial = {1'b0, root, 2'b01};
  assign vsel  = (cvar > agr_pkg::SIGMA_FLOOR_V) ? cvar : agr_pkg::SIGMA_FLOOR_V;
  assign rterm = agr_pkg::rnd_shr(prod, 30);
  assign gsum  = {4'b0, e2} + full[96:30];
  assign vn    = vacc + full[82:30];
  assign put_ok = !out_valid || results.ready;

  always_comb begin
    if ((gamma_w != 32'd0) && e[31])
      s_next = (gsum[66:64] != 3'd0) ? {64{1'b1}} : gsum[63:0];
    else
      s_next = {1'b0, e2};
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      agr_pkg::S_SHOCK: begin ma = {5'b0, root}; mb = {z[31], z}; end
      agr_pkg::S_AR1:   begin ma = {a1[31], a1}; mb = {r0[31], r0}; end
      agr_pkg::S_AR2:   begin ma = {a2[31], a2}; mb = {r1[31], r1}; end
      agr_pkg::S_MA1:   begin ma = {m1[31], m1}; mb = {sh0[31], sh0}; end
      agr_pkg::S_SQ:    begin ma = {e[31], e}; mb = {e[31], e}; end
      agr_pkg::S_GLO:   begin ma = {1'b0, prod[31:0]}; mb = {1'b0, gamma_w}; end
      agr_pkg::S_GHI:   begin ma = {2'b0, e2[62:32]}; mb = {1'b0, gamma_w}; end
      agr_pkg::S_ALO:   begin ma = {1'b0, s[31:0]}; mb = {1'b0, alpha}; end
      agr_pkg::S_AHI:   begin ma = {1'b0, s[63:32]}; mb = {1'b0, alpha}; end
      agr_pkg::S_BLO:   begin ma = {1'b0, cvar[31:0]}; mb = {1'b0, beta}; end
      agr_pkg::S_BHI:   begin ma = {25'b0, cvar[39:32]}; mb = {1'b0, beta}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mu <= '0; a1 <= '0; a2 <= '0; m1 <= '0;
      omega <= '0; alpha <= '0; beta <= '0; gamma_w <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        agr_pkg::REG_MEAN_RETURN:  mu      <= cfg_data[31:0];
        agr_pkg::REG_AR_LAG1:      a1      <= cfg_data[31:0];
        agr_pkg::REG_AR_LAG2:      a2      <= cfg_data[31:0];
        agr_pkg::REG_MA_LAG1:      m1      <= cfg_data[31:0];
        agr_pkg::REG_OMEGA:        omega   <= cfg_data[39:0];
        agr_pkg::REG_SHOCK_WEIGHT: alpha   <= cfg_data[31:0];
        agr_pkg::REG_PERSIST:      beta    <= cfg_data[31:0];
        agr_pkg::REG_DOWNSIDE:     gamma_w <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= agr_pkg::S_IDLE;
      out_valid <= 1'b0;
      r0 <= '0; r1 <= '0; sh0 <= '0; cvar <= '0;
    end else begin
      if (out_valid && results.ready)
        out_valid <= 1'b0;
      case (state)
        agr_pkg::S_IDLE: begin
          if (steps.valid) begin
            is_start <= (steps.op == agr_pkg::OP_START);
            z        <= steps.innovation;
            xs       <= {vsel, 16'b0};
            rem      <= '0;
            root     <= '0;
            cnt      <= 5'd27;
            if (steps.op == agr_pkg::OP_START) begin
              pend_ret   <= '0;
              pend_shock <= '0;
              pend_var   <= steps.start_variance;
              state      <= agr_pkg::S_PUT;
            end else begin
              state <= agr_pkg::S_SQRT;
            end
          end
        end
        agr_pkg::S_SQRT: begin
          xs <= {xs[53:0], 2'b00};
          if (rs >= trial) begin
            rem  <= rs - trial;
            root <= {root[26:0], 1'b1};
          end else begin
            rem  <= rs;
            root <= {root[26:0], 1'b0};
          end
          if (cnt == 5'd0)
            state <= agr_pkg::S_SHOCK;
          else
            cnt <= cnt - 5'd1;
        end
        agr_pkg::S_SHOCK: state <= agr_pkg::S_AR1;
        agr_pkg::S_AR1: begin
          e   <= agr_pkg::sat32(AW'(agr_pkg::rnd_shr(prod, 28)));
          acc <= AW'(mu) + AW'(agr_pkg::sat32(AW'(agr_pkg::rnd_shr(prod, 28))));
          state <= agr_pkg::S_AR2;
        end
        agr_pkg::S_AR2: begin
          if (AR_ORDER >= 1)
            acc <= acc + AW'(rterm);
          state <= agr_pkg::S_MA1;
        end
        agr_pkg::S_MA1: begin
          if (AR_ORDER >= 2)
            acc <= acc + AW'(rterm);
          state <= agr_pkg::S_SQ;
        end
        agr_pkg::S_SQ: begin
          if (MA_ORDER >= 1)
            acc <= acc + AW'(rterm);
          state <= agr_pkg::S_GLO;
        end
        agr_pkg::S_GLO: begin
          e2    <= prod[62:0];
          state <= agr_pkg::S_GHI;
        end
        agr_pkg::S_GHI: begin
          wacc  <= {33'b0, prod[63:0]};
          state <= agr_pkg::S_SADD;
        end
        agr_pkg::S_SADD: begin
          s     <= s_next;
          state <= agr_pkg::S_ALO;
        end
        agr_pkg::S_ALO: state <= agr_pkg::S_AHI;
        agr_pkg::S_AHI: begin
          wacc  <= {33'b0, prod[63:0]};
          state <= agr_pkg::S_BLO;
        end
        agr_pkg::S_BLO: begin
          vacc  <= {13'b0, omega} + {2'b0, full[96:46]};
          state <= agr_pkg::S_BHI;
        end
        agr_pkg::S_BHI: begin
          wacc  <= {33'b0, prod[63:0]};
          state <= agr_pkg::S_FIN;
        end
        agr_pkg::S_FIN: begin
          pend_ret   <= agr_pkg::sat32(acc);
          pend_shock <= e;
          if (vn < agr_pkg::VAR_LO)
            pend_var <= agr_pkg::VAR_LO[39:0];
          else if (vn > agr_pkg::VAR_HI)
            pend_var <= agr_pkg::VAR_HI[39:0];
          else
            pend_var <= vn[39:0];
          state <= agr_pkg::S_PUT;
        end
        agr_pkg::S_PUT: begin
          if (put_ok) begin
            out_ret   <= pend_ret;
            out_shock <= pend_shock;
            out_var   <= pend_var;
            out_valid <= 1'b1;
            cvar      <= pend_var;
            if (is_start) begin
              r0 <= '0; r1 <= '0; sh0 <= '0;
            end else begin
              r1  <= r0;
              r0  <= pend_ret;
              sh0 <= pend_shock;
            end
            state <= agr_pkg::S_IDLE;
          end
        end
        default: state <= agr_pkg::S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for arma_garch_return_step: directed and random step/start words.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [agr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
  localparam logic [63:0] ONES64 = 64'hffff_ffff_ffff_ffff;

  typedef struct {
    logic        op;
    logic [31:0] innovation;
    logic [39:0] start_variance;
  } step_word_t;

  typedef struct {
    logic [31:0] step_return;
    logic [31:0] step_shock;
    logic [39:0] next_variance;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [agr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [agr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  agr_in_if  steps ();
  agr_out_if results ();

  arma_garch_return_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .steps     (steps),
    .results   (results)
  );

  // predictor state
  logic [39:0] cfg_shadow [8];
  longint      ret_hist [2];
  longint      shock_hist;
  logic [39:0] cond_var;

  step_word_t   word_q [$];
  result_word_t expected_results [$];
  step_word_t   on_bus;
  int           in_gap = 0;
  int           out_hold = 0;
  bit           long_hold_req = 0;
  bit           idle_on = 1;
  bit           calm = 0;
  int           errors = 0;
  logic [agr_pkg::CFG_IDX_W-1:0] reg_order [8] = '{
    agr_pkg::REG_MEAN_RETURN, agr_pkg::REG_AR_LAG1, agr_pkg::REG_AR_LAG2,
    agr_pkg::REG_MA_LAG1, agr_pkg::REG_OMEGA, agr_pkg::REG_SHOCK_WEIGHT,
    agr_pkg::REG_PERSIST, agr_pkg::REG_DOWNSIDE};

  initial forever #1 clk = ~clk;

  function automatic longint round_shift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ONES64 : s[63:0];
  endfunction

  function automatic logic [63:0] scale_sat(logic [63:0] x, logic [31:0] w, int sh);
    logic [127:0] p;
    p = ({64'd0, x} * {96'd0, w}) >> sh;
    return (|p[127:64]) ? ONES64 : p[63:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_word_t predict_step(step_word_t w);
    result_word_t res;
    logic [63:0] v, sigma, e2, s, vn;
    longint e, r;
    if (w.op == agr_pkg::OP_START) begin
      ret_hist[0] = 0;
      ret_hist[1] = 0;
      shock_hist = 0;
      cond_var = w.start_variance;
      res.step_return = '0;
      res.step_shock = '0;
      res.next_variance = cond_var;
      return res;
    end
    v = (cond_var > agr_pkg::SIGMA_FLOOR_V) ? 64'(cond_var) : 64'(agr_pkg::SIGMA_FLOOR_V);
    sigma = root64(v << 16);
    e = clip32(round_shift(longint'(sigma) * longint'($signed(w.innovation)), 28));
    r = longint'($signed(cfg_shadow[agr_pkg::REG_MEAN_RETURN][31:0])) + e
      + round_shift(longint'($signed(cfg_shadow[agr_pkg::REG_AR_LAG1][31:0])) * ret_hist[0],
                    30)
      + round_shift(longint'($signed(cfg_shadow[agr_pkg::REG_AR_LAG2][31:0])) * ret_hist[1],
                    30)
      + round_shift(longint'($signed(cfg_shadow[agr_pkg::REG_MA_LAG1][31:0])) * shock_hist,
                    30);
    r = clip32(r);
    e2 = 64'(e * e);
    s = e2;
    if (cfg_shadow[agr_pkg::REG_DOWNSIDE][31:0] != 0 && e < 0)
      s = add_sat(s, scale_sat(e2, cfg_shadow[agr_pkg::REG_DOWNSIDE][31:0], 30));
    vn = 64'(cfg_shadow[agr_pkg::REG_OMEGA]);
    vn = add_sat(vn, scale_sat(s, cfg_shadow[agr_pkg::REG_SHOCK_WEIGHT][31:0], 46));
    vn = add_sat(vn, scale_sat(64'(cond_var), cfg_shadow[agr_pkg::REG_PERSIST][31:0], 30));
    if (vn < 64'(agr_pkg::VAR_LO)) vn = 64'(agr_pkg::VAR_LO);
    if (vn > 64'(agr_pkg::VAR_HI)) vn = 64'(agr_pkg::VAR_HI);
    cond_var = vn[39:0];
    ret_hist[1] = ret_hist[0];
    ret_hist[0] = r;
    shock_hist = e;
    res.step_return = r[31:0];
    res.step_shock = e[31:0];
    res.next_variance = vn[39:0];
    return res;
  endfunction

  function automatic void queue_word(step_word_t w);
    word_q = {word_q, w};
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      steps.valid <= 1'b0;
    end else begin
      if (steps.valid && steps.ready)
        expected_results = {expected_results, predict_step(on_bus)};
      if (!steps.valid || steps.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          steps.valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          on_bus = word_q[0];
          word_q.delete(0);
          steps.op <= on_bus.op;
          steps.innovation <= on_bus.innovation;
          steps.start_variance <= on_bus.start_variance;
          steps.valid <= 1'b1;
          if (!calm && idle_on && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 19);
        end else begin
          steps.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word ret=%h shock=%h var=%h", $time,
                   results.step_return, results.step_shock, results.next_variance);
          errors++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (results.step_return !== want.step_return) begin
            $display("%0t: step_return exp %h got %h", $time, want.step_return,
                     results.step_return);
            errors++;
          end
          if (results.step_shock !== want.step_shock) begin
            $display("%0t: step_shock exp %h got %h", $time, want.step_shock,
                     results.step_shock);
            errors++;
          end
          if (results.next_variance !== want.next_variance) begin
            $display("%0t: next_variance exp %h got %h", $time, want.next_variance,
                     results.next_variance);
            errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        results.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 0;
        out_hold = 400;
        results.ready <= 1'b0;
      end else if (!calm && idle_on && $urandom_range(0, 7) == 0) begin
        out_hold = $urandom_range(0, 18);
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  function automatic step_word_t make_word(logic op, logic [31:0] z, logic [39:0] sv);
    step_word_t w;
    w.op = op;
    w.innovation = z;
    w.start_variance = sv;
    return w;
  endfunction

  function automatic step_word_t random_word();
    logic [31:0] z;
    logic [39:0] sv;
    if ($urandom_range(0, 5) == 0) z = $urandom;
    else z = 32'($signed({1'b0, $urandom_range(0, 32'h3fff_ffff)}) - 33'sd536870912);
    case ($urandom_range(0, 3))
      0: sv = {8'($urandom), 32'($urandom)};
      1: sv = '0;
      default: sv = 40'($urandom_range(10995, 32'hffff_ffff)) << $urandom_range(0, 1);
    endcase
    return make_word($urandom_range(0, 19) == 0 ? agr_pkg::OP_START : agr_pkg::OP_STEP,
                     z, sv);
  endfunction

  task automatic program_regs(input logic [39:0] vals [8]);
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= {8'($urandom), 32'($urandom)};
    @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_index <= reg_order[i];
      cfg_data <= vals[i];
      cfg_shadow[reg_order[i]] = (reg_order[i] == agr_pkg::REG_OMEGA) ? vals[i]
                                                                      : {8'd0, vals[i][31:0]};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (word_q.size() > 0 || steps.valid || expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_run(int n);
    queue_word(make_word(agr_pkg::OP_START, 0, 40'($urandom_range(10995, 32'h7fff_ffff))));
    for (int i = 0; i < n; i++) queue_word(random_word());
    drain();
  endtask

  initial begin
    logic [39:0] vals [8];
    steps.valid = 1'b0;
    steps.op = agr_pkg::OP_STEP;
    steps.innovation = '0;
    steps.start_variance = '0;
    results.ready = 1'b0;
    for (int i = 0; i < 8; i++) cfg_shadow[i] = '0;
    ret_hist[0] = 0;
    ret_hist[1] = 0;
    shock_hist = 0;
    cond_var = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero variance floor, extreme draws, extreme loads
    queue_word(make_word(agr_pkg::OP_STEP, 32'h7fff_ffff, 0));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h8000_0000, 0));
    queue_word(make_word(agr_pkg::OP_START, 0, '0));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h7fff_ffff, 0));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h0000_0001, 0));
    queue_word(make_word(agr_pkg::OP_STEP, 32'hffff_ffff, 0));
    queue_word(make_word(agr_pkg::OP_START, 0, 40'hff_ffff_ffff));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h7fff_ffff, 40'hff_ffff_ffff));
    queue_word(make_word(agr_pkg::OP_START, 32'hffff_ffff, 40'd110));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h8000_0000, 0));
    queue_word(make_word(agr_pkg::OP_START, 0, 40'd10995116278));
    queue_word(make_word(agr_pkg::OP_STEP, 32'hf000_0000, 0));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h1000_0000, 0));
    drain();

    // typical fit, long output stall early on
    vals = '{40'h0000_1000, 40'h1333_3333, 40'hf999_999a, 40'h0ccc_cccd,
             40'd1099512, 40'h0520_0000, 40'h3999_999a, 40'h2000_0000};
    program_regs(vals);
    long_hold_req = 1;
    queue_word(make_word(agr_pkg::OP_START, 0, 40'd1099512));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h8000_0000, 0));
    queue_word(make_word(agr_pkg::OP_STEP, 32'hf000_0000, 0));
    random_run(300);

    // upper extremes
    vals = '{40'hff_7fff_ffff, 40'h00_7fff_ffff, 40'hff_7fff_ffff, 40'h00_7fff_ffff,
             40'hff_ffff_ffff, 40'hff_ffff_ffff, 40'h00_ffff_ffff, 40'h00_ffff_ffff};
    program_regs(vals);
    queue_word(make_word(agr_pkg::OP_START, 0, 40'hff_ffff_ffff));
    queue_word(make_word(agr_pkg::OP_STEP, 32'h8000_0000, 0));
    random_run(200);

    // lower extremes
    vals = '{40'h00_8000_0000, 40'hff_8000_0000, 40'h00_8000_0000, 40'h00_8000_0000,
             40'h0, 40'h0, 40'h0, 40'h0};
    program_regs(vals);
    idle_on = 0;
    random_run(200);
    idle_on = 1;

    // random settings
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 8; i++) vals[i] = {8'($urandom), 32'($urandom)};
      if (p == 0) begin
        vals[4] = 40'($urandom_range(0, 32'h00ff_ffff));
        vals[5] = 40'($urandom_range(0, 32'h0fff_ffff));
        vals[6] = 40'($urandom_range(0, 32'h4000_0000));
      end
      program_regs(vals);
      random_run(160);
    end

    // typical fit again, no idling
    vals = '{40'hff_ffff_f000, 40'h1999_999a, 40'h0666_6666, 40'hf333_3333,
             40'd219902, 40'h0666_6666, 40'h3666_6666, 40'h4000_0000};
    program_regs(vals);
    calm = 1;
    random_run(200);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
